[rtl/hc256_pkg.sv]
// ----------------------------------------------------------------------------
// hc256_pkg
// shared types and constants of the hc-256 keystream generator
// ----------------------------------------------------------------------------
`default_nettype none

package hc256_pkg;

    localparam int unsigned TBL_DEPTH   = 1024;
    localparam int unsigned TBL_AW      = 10;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned CFG_AW      = 3;
    localparam int unsigned CTR_W       = 11;
    localparam int unsigned EXP_W       = 12;
    localparam int unsigned WARM_W      = 12;
    localparam logic [EXP_W-1:0]  EXP_FIRST = 12'd16;
    localparam logic [EXP_W-1:0]  EXP_LAST  = 12'd2559;
    localparam logic [EXP_W-1:0]  P_START   = 12'd512;
    localparam logic [EXP_W-1:0]  Q_START   = 12'd1536;
    localparam logic [WARM_W-1:0] WARM_LAST = 12'd4095;

    // request kinds on the input tuser
    localparam logic REQ_INIT = 1'b0;
    localparam logic REQ_KS   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_STEP,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        PH_RD_I,
        PH_RD_I10,
        PH_RD_I3,
        PH_RD_I1023,
        PH_RD_I12,
        PH_WRITE,
        PH_QSUM1,
        PH_QSUM2,
        PH_QSUM3,
        PH_DONE
    } phase_t;

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
        rotr32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] mix1(input logic [31:0] x);
        mix1 = rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] mix2(input logic [31:0] x);
        mix2 = rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

[rtl/hc256_ram.sv]
// ----------------------------------------------------------------------------
// hc256_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module hc256_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/hc256_keystream_generator.sv]
// ----------------------------------------------------------------------------
// hc256_keystream_generator
// hc-256 stream cipher core with tables p and q held in two block rams
// ----------------------------------------------------------------------------
// Usage:
//   key and iv are written through cfg_we/cfg_addr/cfg_wdata while idle.
//   input items (s_axis_*): tuser[0] selects initialize (0) or keystream (1),
//   tuser[1] asks for the keystream to be xored with tdata, tlast is echoed.
//   every input item gives exactly one output item (m_axis_*), tuser set
//   for the answer to an initialize, whose tdata is zero.
// Operation:
//   a cipher step reads the own table five times and the other table five
//   times through the single read port of each ram. a keystream item is one
//   step and then a load of the output register; initialize expands 2544
//   words (one word a cycle) and then runs 4096 steps.
//   one item is in work at a time; s_axis_tready is high only when idle.
// Reset: clears control, step counter and key/iv registers; tables are
//   undefined until the first initialize.
// Stall: a finished result waits in the output register while the next item
//   is accepted; a following result waits until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hc256_keystream_generator
    import hc256_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_AW-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [31:0]        s_axis_tdata,   // data_in
    input  wire logic [1:0]         s_axis_tuser,   // req_type, xor_with_input
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [31:0]        m_axis_tdata,   // data_out
    output logic      [0:0]         m_axis_tuser,   // was_init
    output logic                    m_axis_tlast
);

    // key and iv registers
    logic [CFG_W-1:0] cfg_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
            begin
                cfg_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [CTR_W-1:0]    ctr_reg, ctr_next;
    logic [EXP_W-1:0]    n_reg, n_next;
    logic [WARM_W-1:0]   warm_reg, warm_next;
    logic                init_reg, init_next;
    logic                xor_reg, xor_next;
    logic                last_reg, last_next;
    logic [WORD_W-1:0]   din_reg, din_next;
    logic [WORD_W-1:0]   win_reg [16];
    logic [WORD_W-1:0]   win_next [16];
    logic [WORD_W-1:0]   sum_reg, sum_next;
    logic [WORD_W-1:0]   x3_reg, x3_next;
    logic [WORD_W-1:0]   u_reg, u_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]   res_reg, res_next;
    logic                mv_reg, mv_next;
    logic [WORD_W-1:0]   md_reg, md_next;
    logic                mu_reg, mu_next;
    logic                ml_reg, ml_next;

    // ram ports
    logic                p_we, q_we;
    logic [TBL_AW-1:0]   p_waddr, q_waddr, p_raddr, q_raddr;
    logic [WORD_W-1:0]   p_wdata, q_wdata, p_rdata, q_rdata;

    hc256_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_table_p (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    hc256_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_table_q (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // own table is p in the lower half of the counter range
    logic              own_p;
    logic [TBL_AW-1:0] idx_i;
    logic [WORD_W-1:0] own_rd, oth_rd, exp_w;
    logic [TBL_AW-1:0] own_raddr, oth_raddr;
    logic              own_we;
    logic [WORD_W-1:0] own_wdata;
    logic              s_acc;

    assign own_p  = ~ctr_reg[CTR_W-1];
    assign idx_i  = ctr_reg[TBL_AW-1:0];
    assign own_rd = own_p ? p_rdata : q_rdata;
    assign oth_rd = own_p ? q_rdata : p_rdata;
    assign s_acc  = s_axis_tvalid && s_axis_tready;

    // expansion recurrence over the sliding window
    assign exp_w = mix2(win_reg[14]) + win_reg[9] + mix1(win_reg[1]) + win_reg[0]
                 + {20'd0, n_reg};

    // ram port steering
    always_comb
    begin
        p_raddr = own_p ? own_raddr : oth_raddr;
        q_raddr = own_p ? oth_raddr : own_raddr;
        if (state_reg == ST_EXPAND)
        begin
            p_we    = (n_reg >= P_START) && (n_reg < Q_START);
            q_we    = (n_reg >= Q_START);
            p_waddr = TBL_AW'(n_reg - P_START);
            q_waddr = TBL_AW'(n_reg - Q_START);
            p_wdata = exp_w;
            q_wdata = exp_w;
        end
        else
        begin
            p_we    = own_we && own_p;
            q_we    = own_we && !own_p;
            p_waddr = idx_i;
            q_waddr = idx_i;
            p_wdata = own_wdata;
            q_wdata = own_wdata;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_RD_I;
            ctr_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ctr_reg   <= ctr_next;
            mv_reg    <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        warm_reg <= warm_next;
        init_reg <= init_next;
        xor_reg  <= xor_next;
        last_reg <= last_next;
        din_reg  <= din_next;
        sum_reg  <= sum_next;
        x3_reg   <= x3_next;
        u_reg    <= u_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        md_reg   <= md_next;
        mu_reg   <= mu_next;
        ml_reg   <= ml_next;
        for (int k = 0; k < 16; k++)
        begin
            win_reg[k] <= win_next[k];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ctr_next   = ctr_reg;
        n_next     = n_reg;
        warm_next  = warm_reg;
        init_next  = init_reg;
        xor_next   = xor_reg;
        last_next  = last_reg;
        din_next   = din_reg;
        sum_next   = sum_reg;
        x3_next    = x3_reg;
        u_next     = u_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ml_next    = ml_reg;
        win_next   = win_reg;
        own_raddr  = idx_i;
        oth_raddr  = '0;
        own_we     = 1'b0;
        own_wdata  = sum_reg + oth_rd;
        mv_next    = mv_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    init_next = (s_axis_tuser[0] == REQ_INIT);
                    xor_next  = s_axis_tuser[1];
                    last_next = s_axis_tlast;
                    din_next  = s_axis_tdata;
                    phase_next = PH_RD_I;
                    if (s_axis_tuser[0] == REQ_INIT)
                    begin
                        // key words then iv words fill the window
                        for (int k = 0; k < 8; k++)
                        begin
                            win_next[k]     = (k % 2 == 1) ? cfg_reg[k / 2][63:32]
                                                           : cfg_reg[k / 2][31:0];
                            win_next[8 + k] = (k % 2 == 1) ? cfg_reg[4 + k / 2][63:32]
                                                           : cfg_reg[4 + k / 2][31:0];
                        end
                        n_next     = EXP_FIRST;
                        state_next = ST_EXPAND;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end

            ST_EXPAND:
            begin
                for (int k = 0; k < 15; k++)
                begin
                    win_next[k] = win_reg[k + 1];
                end
                win_next[15] = exp_w;
                n_next       = n_reg + 1'b1;
                if (n_reg == EXP_LAST)
                begin
                    ctr_next   = '0;
                    warm_next  = '0;
                    phase_next = PH_RD_I;
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                phase_next = phase_t'(phase_reg + 1'b1);
                unique case (phase_reg)
                    PH_RD_I:     own_raddr = idx_i;
                    PH_RD_I10:   own_raddr = idx_i - TBL_AW'(10);
                    PH_RD_I3:
                    begin
                        own_raddr = idx_i - TBL_AW'(3);
                        sum_next  = sum_reg;
                    end
                    PH_RD_I1023:
                    begin
                        own_raddr = idx_i + TBL_AW'(1);
                        x3_next   = own_rd;
                    end
                    PH_RD_I12:
                    begin
                        own_raddr = idx_i - TBL_AW'(12);
                        oth_raddr = TBL_AW'(x3_reg ^ own_rd);
                        sum_next  = sum_reg + (rotr32(x3_reg, 10) ^ rotr32(own_rd, 23));
                    end
                    PH_WRITE:
                    begin
                        own_we    = 1'b1;
                        sum_next  = sum_reg + oth_rd;
                        u_next    = own_rd;
                        oth_raddr = {2'b00, own_rd[7:0]};
                    end
                    PH_QSUM1:
                    begin
                        acc_next  = oth_rd;
                        oth_raddr = {2'b01, u_reg[15:8]};
                    end
                    PH_QSUM2:
                    begin
                        acc_next  = acc_reg + oth_rd;
                        oth_raddr = {2'b10, u_reg[23:16]};
                    end
                    PH_QSUM3:
                    begin
                        acc_next  = acc_reg + oth_rd;
                        oth_raddr = {2'b11, u_reg[31:24]};
                    end
                    PH_DONE:
                    begin
                        ctr_next   = ctr_reg + 1'b1;
                        phase_next = PH_RD_I;
                        if (init_reg)
                        begin
                            warm_next = warm_reg + 1'b1;
                            res_next  = '0;
                            if (warm_reg == WARM_LAST)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        else
                        begin
                            res_next   = ((acc_reg + oth_rd) ^ sum_reg)
                                       ^ (xor_reg ? din_reg : '0);
                            state_next = ST_FINISH;
                        end
                    end
                    default:     phase_next = PH_RD_I;
                endcase
                // own[i] + own[i10] gathered as the first two reads arrive
                if (phase_reg == PH_RD_I10)
                begin
                    sum_next = own_rd;
                end
                else if (phase_reg == PH_RD_I3)
                begin
                    sum_next = sum_reg + own_rd;
                end
            end

            ST_FINISH:
            begin
                if (!mv_reg || m_axis_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = res_reg;
                    mu_next    = init_reg;
                    ml_next    = last_reg;
                    state_next = ST_IDLE;
                end
            end

            default:     state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = mv_reg;
    assign m_axis_tdata    = md_reg;
    assign m_axis_tuser[0] = mu_reg;
    assign m_axis_tlast    = ml_reg;

endmodule

`default_nettype wire

[rtl/hc256_checker.sv]
// ----------------------------------------------------------------------------
// hc256_checker
// port-level checks of the keystream generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module hc256_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one item at a time: busy after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // initialize answers carry zero data
    a_init_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("initialize answer with data");

    // no result rises in the cycle right after an accept
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result without processing time");

endmodule

bind hc256_keystream_generator hc256_checker u_hc256_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);

`default_nettype wire
